### src/itc_pkg.sv
// package: word types and codes of the interval timer counters
`default_nettype none

package itc_pkg;

    // defaults for the top level parameters
    localparam int NUM_COUNTERS_DEF = 3;
    localparam int COUNT_BITS_DEF   = 16;

    // action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // port offsets
    localparam logic [1:0] CTRL_PORT = 2'd3;

    // control word select code for read-back
    localparam logic [1:0] SEL_READBACK = 2'd3;

    // access modes
    localparam logic [1:0] ACC_LATCH = 2'd0;
    localparam logic [1:0] ACC_LOW   = 2'd1;
    localparam logic [1:0] ACC_HIGH  = 2'd2;
    localparam logic [1:0] ACC_BOTH  = 2'd3;

    // counting modes after folding 6 and 7 onto 2 and 3
    localparam logic [2:0] MODE_ONESHOT = 3'd0;
    localparam logic [2:0] MODE_GATE1   = 3'd1;
    localparam logic [2:0] MODE_RATE    = 3'd2;
    localparam logic [2:0] MODE_SQUARE  = 3'd3;
    localparam logic [2:0] MODE_STROBE  = 3'd4;
    localparam logic [2:0] MODE_GATE5   = 3'd5;

    // input word: one tick or one bus write
    typedef struct packed {
        logic       action;
        logic [1:0] port;
        logic [7:0] write_data;
    } cmd_word_t;

    // result word: output levels after the step and the interrupt pulse
    typedef struct packed {
        logic out_zero;
        logic out_one;
        logic out_two;
        logic irq_pulse;
    } res_word_t;

    // fold modes 6 and 7 onto 2 and 3
    function automatic logic [2:0] eff_mode(input logic [2:0] m);
        logic [2:0] r;
        r = m;
        if (m[2] && m[1])
        begin
            r = {1'b0, m[1:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/interval_timer_counters_core.sv
// interval_timer_counters_core: three-counter interval timer, write-only bus
//
// Usage: each word on the cmd channel is either one timer clock tick
// (action = tick) or one byte written to port 0..2 (count data) or port 3
// (control word). Every accepted word yields exactly one res word holding
// the output levels of the counters after that step and an interrupt pulse
// that marks a rising edge of counter 0's output on a tick.
// Latency: the res word is valid in the cycle after the cmd word is taken.
// Throughput: one word per cycle when not stalled; all counters update
// together in a single pass of logic between the state and result registers.
// Stall: the result register holds its word while res_stall is high; cmd_stall
// rises only when that register is full and stalled, so a new word is taken
// in the same cycle the previous result leaves.
// Reset: rst_n clears all counters to stopped with output low, access mode
// low-then-high and count zero; no result is pending after reset.
// Counters at or above NUM_COUNTERS are absent and read back as output low.
`default_nettype none

module interval_timer_counters_core #(
    parameter int NUM_COUNTERS = itc_pkg::NUM_COUNTERS_DEF,
    parameter int COUNT_BITS   = itc_pkg::COUNT_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cmd_valid,
    output logic               cmd_stall,
    input  itc_pkg::cmd_word_t cmd,
    output logic               res_valid,
    input  wire                res_stall,
    output itc_pkg::res_word_t res
);

    localparam int CW = COUNT_BITS + 1;

    // handshake
    logic cmd_fire;
    logic res_valid_reg;
    itc_pkg::res_word_t res_reg;

    assign cmd_stall = res_valid_reg && res_stall;
    assign cmd_fire  = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // per-counter state
    logic [CW-1:0]         cnt_reg    [NUM_COUNTERS];
    logic [CW-1:0]         cnt_next   [NUM_COUNTERS];
    logic [COUNT_BITS-1:0] reload_reg [NUM_COUNTERS];
    logic [COUNT_BITS-1:0] reload_next[NUM_COUNTERS];
    logic [2:0]            mode_reg   [NUM_COUNTERS];
    logic [2:0]            mode_next  [NUM_COUNTERS];
    logic [1:0]            acc_reg    [NUM_COUNTERS];
    logic [1:0]            acc_next   [NUM_COUNTERS];
    logic                  hbn_reg    [NUM_COUNTERS];
    logic                  hbn_next   [NUM_COUNTERS];
    logic [7:0]            low_reg    [NUM_COUNTERS];
    logic [7:0]            low_next   [NUM_COUNTERS];
    logic                  armed_reg  [NUM_COUNTERS];
    logic                  armed_next [NUM_COUNTERS];
    logic                  lvl_reg    [NUM_COUNTERS];
    logic                  lvl_next   [NUM_COUNTERS];

    // decoded control word fields
    logic [1:0] ctl_sel;
    logic [1:0] ctl_acc;
    logic [2:0] ctl_mode;
    logic       ctl_ok;
    logic       is_tick;

    assign ctl_sel  = cmd.write_data[7:6];
    assign ctl_acc  = cmd.write_data[5:4];
    assign ctl_mode = cmd.write_data[3:1];
    assign ctl_ok   = (cmd.action == itc_pkg::ACT_WRITE) && (cmd.port == itc_pkg::CTRL_PORT)
                      && (ctl_sel != itc_pkg::SEL_READBACK) && (ctl_acc != itc_pkg::ACC_LATCH);
    assign is_tick  = (cmd.action == itc_pkg::ACT_TICK);

    for (genvar gi = 0; gi < NUM_COUNTERS; gi++)
    begin : g_ctr
        // next state of one counter
        always_comb
        begin
            logic [CW-1:0]         per;
            logic [CW-1:0]         cnt_m1;
            logic [CW-1:0]         dec;
            logic [CW:0]           per_p1;
            logic [CW-1:0]         half_up;
            logic [CW-1:0]         half_dn;
            logic [15:0]           val16;
            logic [COUNT_BITS-1:0] nrel;
            logic [CW-1:0]         nper;
            logic [CW:0]           nper_p1;
            logic                  do_load;
            logic [2:0]            em;

            cnt_next[gi]    = cnt_reg[gi];
            reload_next[gi] = reload_reg[gi];
            mode_next[gi]   = mode_reg[gi];
            acc_next[gi]    = acc_reg[gi];
            hbn_next[gi]    = hbn_reg[gi];
            low_next[gi]    = low_reg[gi];
            armed_next[gi]  = armed_reg[gi];
            lvl_next[gi]    = lvl_reg[gi];

            // period of the present reload value, zero meaning full range
            per = (reload_reg[gi] == '0) ? (CW'(1) << COUNT_BITS) : CW'(reload_reg[gi]);
            per_p1  = {1'b0, per} + (CW + 1)'(1);
            half_up = per_p1[CW:1];
            half_dn = per >> 1;
            cnt_m1  = cnt_reg[gi] - CW'(1);
            dec     = (cnt_reg[gi] != '0) ? cnt_m1 : cnt_reg[gi];
            em      = itc_pkg::eff_mode(mode_reg[gi]);

            // data byte assembly
            do_load = 1'b0;
            val16   = 16'd0;
            case (acc_reg[gi])
                itc_pkg::ACC_LOW:  val16 = {8'd0, cmd.write_data};
                itc_pkg::ACC_HIGH: val16 = {cmd.write_data, 8'd0};
                default:           val16 = {cmd.write_data, low_reg[gi]};
            endcase
            nrel    = COUNT_BITS'(val16);
            nper    = (nrel == '0) ? (CW'(1) << COUNT_BITS) : CW'(nrel);
            nper_p1 = {1'b0, nper} + (CW + 1)'(1);

            if (is_tick)
            begin
                if (armed_reg[gi])
                begin
                    case (em)
                        itc_pkg::MODE_ONESHOT:
                        begin
                            cnt_next[gi] = dec;
                            if (dec == '0)
                            begin
                                lvl_next[gi]   = 1'b1;
                                armed_next[gi] = 1'b0;
                            end
                        end
                        itc_pkg::MODE_RATE:
                        begin
                            if (cnt_reg[gi] <= CW'(1))
                            begin
                                cnt_next[gi] = per;
                                lvl_next[gi] = 1'b1;
                            end
                            else
                            begin
                                cnt_next[gi] = cnt_m1;
                                if (cnt_m1 == CW'(1))
                                begin
                                    lvl_next[gi] = 1'b0;
                                end
                            end
                        end
                        itc_pkg::MODE_SQUARE:
                        begin
                            cnt_next[gi] = dec;
                            if (dec == '0)
                            begin
                                if (lvl_reg[gi] && (half_dn != '0))
                                begin
                                    lvl_next[gi] = 1'b0;
                                    cnt_next[gi] = half_dn;
                                end
                                else
                                begin
                                    lvl_next[gi] = 1'b1;
                                    cnt_next[gi] = half_up;
                                end
                            end
                        end
                        itc_pkg::MODE_STROBE:
                        begin
                            if (!lvl_reg[gi])
                            begin
                                lvl_next[gi]   = 1'b1;
                                armed_next[gi] = 1'b0;
                            end
                            else
                            begin
                                cnt_next[gi] = dec;
                                if (dec == '0)
                                begin
                                    lvl_next[gi] = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            // gate modes hold their count
                        end
                    endcase
                end
            end
            else if (cmd.port == itc_pkg::CTRL_PORT)
            begin
                // control word
                if (ctl_ok && (ctl_sel == 2'(gi)))
                begin
                    acc_next[gi]   = ctl_acc;
                    mode_next[gi]  = ctl_mode;
                    armed_next[gi] = 1'b0;
                    hbn_next[gi]   = 1'b0;
                    lvl_next[gi]   = (ctl_mode != itc_pkg::MODE_ONESHOT);
                end
            end
            else if (cmd.port == 2'(gi))
            begin
                // count data byte
                case (acc_reg[gi])
                    itc_pkg::ACC_LOW:  do_load = 1'b1;
                    itc_pkg::ACC_HIGH: do_load = 1'b1;
                    default:
                    begin
                        if (!hbn_reg[gi])
                        begin
                            low_next[gi] = cmd.write_data;
                            hbn_next[gi] = 1'b1;
                        end
                        else
                        begin
                            hbn_next[gi] = 1'b0;
                            do_load      = 1'b1;
                        end
                    end
                endcase
            end

            // load a completed count
            if (do_load)
            begin
                reload_next[gi] = nrel;
                armed_next[gi]  = 1'b1;
                case (em)
                    itc_pkg::MODE_ONESHOT:
                    begin
                        lvl_next[gi] = 1'b0;
                        cnt_next[gi] = nper;
                    end
                    itc_pkg::MODE_SQUARE:
                    begin
                        lvl_next[gi] = 1'b1;
                        cnt_next[gi] = nper_p1[CW:1];
                    end
                    default: cnt_next[gi] = nper;
                endcase
            end
        end

        // state registers of one counter
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cnt_reg[gi]    <= '0;
                reload_reg[gi] <= '0;
                mode_reg[gi]   <= itc_pkg::MODE_ONESHOT;
                acc_reg[gi]    <= itc_pkg::ACC_BOTH;
                hbn_reg[gi]    <= 1'b0;
                low_reg[gi]    <= '0;
                armed_reg[gi]  <= 1'b0;
                lvl_reg[gi]    <= 1'b0;
            end
            else if (cmd_fire)
            begin
                cnt_reg[gi]    <= cnt_next[gi];
                reload_reg[gi] <= reload_next[gi];
                mode_reg[gi]   <= mode_next[gi];
                acc_reg[gi]    <= acc_next[gi];
                hbn_reg[gi]    <= hbn_next[gi];
                low_reg[gi]    <= low_next[gi];
                armed_reg[gi]  <= armed_next[gi];
                lvl_reg[gi]    <= lvl_next[gi];
            end
        end
    end

    // output levels, absent counters read low
    logic [2:0] lvl_all;
    logic       irq_next;

    always_comb
    begin
        lvl_all = '0;
        for (int i = 0; i < NUM_COUNTERS; i++)
        begin
            lvl_all[i] = lvl_next[i];
        end
    end

    assign irq_next = is_tick && !lvl_reg[0] && lvl_next[0];

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            res_reg.out_zero  <= lvl_all[0];
            res_reg.out_one   <= lvl_all[1];
            res_reg.out_two   <= lvl_all[2];
            res_reg.irq_pulse <= irq_next;
        end
    end

    // checks
    a_write_no_irq: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (cmd.action == itc_pkg::ACT_WRITE) |=> !res_reg.irq_pulse)
        else $error("interrupt pulse on a bus write");

    a_irq_high: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.irq_pulse |-> res_reg.out_zero)
        else $error("interrupt pulse with counter 0 output low");

    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> res_valid_reg)
        else $error("accepted word produced no result");

    a_oneshot_low: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg[0] && (mode_reg[0] == itc_pkg::MODE_ONESHOT) |-> !lvl_reg[0])
        else $error("counting one-shot with output high");

    a_absent_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> ((NUM_COUNTERS > 1) || !res_reg.out_one)
                          && ((NUM_COUNTERS > 2) || !res_reg.out_two))
        else $error("absent counter drives output high");

endmodule

`default_nettype wire
